// ===== rtl/attitude_mode_supervisor_assert.svh =====
// Assertion macros for the attitude mode supervisor.
// Each check is clocked on clock and is off while reset is high.
`ifndef ATTITUDE_MODE_SUPERVISOR_ASSERT_SVH
`define ATTITUDE_MODE_SUPERVISOR_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define AMS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ams assertion failed");

// Next-cycle implication.
`define AMS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ams assertion failed");

`else

`define AMS_ASSERT_NOW(label, ante, cons)
`define AMS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/ams_pkg.sv =====
package ams_pkg;

   // Timestamp width
   localparam int TIME_BITS = 48;

   // Pointing error at or below which sun acquisition counts as settled (0.1745 rad, Q3.16)
   localparam logic [18:0] SUN_SETTLED_ERROR = 19'd11438;

   // Settle counter ceiling
   localparam logic [15:0] STABLE_MAX = 16'hFFFF;

   // Configuration register indexes
   localparam logic [2:0] CSR_DETUMBLE_ENTRY_RATE   = 3'd0;
   localparam logic [2:0] CSR_DETUMBLE_EXIT_RATE    = 3'd1;
   localparam logic [2:0] CSR_EXCESSIVE_RATE        = 3'd2;
   localparam logic [2:0] CSR_MIN_CONFIDENCE        = 3'd3;
   localparam logic [2:0] CSR_DETUMBLE_SETTLE_TICKS = 3'd4;
   localparam logic [2:0] CSR_SUN_SETTLE_TICKS      = 3'd5;
   localparam logic [2:0] CSR_ESTIMATE_STALE_US     = 3'd6;

   typedef enum logic [3:0] {
      MODE_BOOT     = 4'd0,
      MODE_SAFE     = 4'd1,
      MODE_DETUMBLE = 4'd2,
      MODE_SUN_ACQ  = 4'd3,
      MODE_SUN_PT   = 4'd4,
      MODE_EARTH    = 4'd5,
      MODE_SLEW     = 4'd6,
      MODE_TARGET   = 4'd7,
      MODE_SCIENCE  = 4'd8
   } mode_type;

   typedef struct packed {
      logic [19:0] detumble_entry_rate;
      logic [19:0] detumble_exit_rate;
      logic [19:0] excessive_rate;
      logic [15:0] min_confidence;
      logic [15:0] detumble_settle_ticks;
      logic [15:0] sun_settle_ticks;
      logic [31:0] estimate_stale_us;
   } cfg_type;

   typedef struct packed {
      logic                 request_valid;
      logic [3:0]           mode_request;
      logic                 critical_fault;
      logic [2:0]           sensor_flags;
      logic [TIME_BITS-1:0] sensor_time;
      logic [TIME_BITS-1:0] attitude_time;
      logic [2:0]           attitude_flags;
      logic [15:0]          confidence;
      logic [19:0]          rate_mag;
      logic [1:0]           reference_flags;
      logic [18:0]          pointing_error;
      logic                 slew_done;
   } tick_type;

   typedef struct packed {
      mode_type    mode;
      mode_type    requested;
      logic [15:0] stable;
   } state_type;

   // Result of one tick beside the next state
   typedef struct packed {
      logic [1:0] entries;
      logic       reject;
   } event_type;

endpackage

// ===== rtl/ams_step.sv =====
module ams_step (
   input  ams_pkg::cfg_type   cfg,
   input  ams_pkg::tick_type  tick,
   input  ams_pkg::state_type cur,
   output ams_pkg::state_type nxt,
   output ams_pkg::event_type evt
);

   typedef struct packed {
      ams_pkg::state_type st;
      logic [1:0]         entries;
   } walk_type;

   logic sensors_ready;
   logic attitude_ready;
   logic data_fresh;
   logic sun_ok;
   logic nadir_ok;
   logic target_ok;
   logic [ams_pkg::TIME_BITS-1:0] age;
   walk_type w;
   logic done;
   logic reject;

   // Enter a mode; nothing happens when already there
   function automatic walk_type enter_mode(walk_type wi, ams_pkg::mode_type target);
      walk_type wo;
      wo = wi;
      if (wi.st.mode != target) begin
         wo.st.mode   = target;
         wo.st.stable = '0;
         wo.entries   = wi.entries + 2'd1;
      end
      return wo;
   endfunction

   function automatic logic [15:0] bump(logic [15:0] s);
      return (s != ams_pkg::STABLE_MAX) ? s + 16'd1 : s;
   endfunction

   function automatic logic allowed(ams_pkg::mode_type m, logic sens, logic att,
                                    logic sun, logic nadir, logic tgt);
      logic ok;
      case (m)
         ams_pkg::MODE_SAFE:     ok = 1'b1;
         ams_pkg::MODE_DETUMBLE: ok = sens;
         ams_pkg::MODE_SUN_ACQ,
         ams_pkg::MODE_SUN_PT:   ok = att & sun;
         ams_pkg::MODE_EARTH:    ok = att & nadir;
         ams_pkg::MODE_SLEW,
         ams_pkg::MODE_TARGET,
         ams_pkg::MODE_SCIENCE:  ok = att & tgt;
         default:                ok = 1'b0;
      endcase
      return ok;
   endfunction

   // Readiness and freshness of this snapshot
   assign sensors_ready  = (tick.sensor_time != '0) && (tick.sensor_flags[1:0] == 2'b11);
   assign attitude_ready = tick.attitude_flags[0] && (tick.attitude_time != '0) &&
                           (tick.confidence >= cfg.min_confidence) && tick.attitude_flags[1];
   assign age            = tick.sensor_time - tick.attitude_time;
   assign data_fresh     = (tick.sensor_time != '0) && (tick.attitude_time != '0) &&
                           (tick.attitude_time <= tick.sensor_time) &&
                           (age <= ams_pkg::TIME_BITS'(cfg.estimate_stale_us));
   assign sun_ok         = tick.sensor_flags[2] && tick.reference_flags[0];
   assign nadir_ok       = tick.reference_flags[1];
   assign target_ok      = tick.attitude_flags[2];

   // Walk the mode rules in priority order
   always_comb begin
      w.st      = cur;
      w.entries = 2'd0;
      reject    = 1'b0;
      done      = 1'b0;

      // Apply the request first
      if (tick.request_valid) begin
         if (tick.mode_request >= ams_pkg::MODE_SAFE &&
             tick.mode_request <= ams_pkg::MODE_SCIENCE) begin
            w.st.requested = ams_pkg::mode_type'(tick.mode_request);
         end else begin
            reject = 1'b1;
         end
      end

      if (tick.critical_fault) begin
         w    = enter_mode(w, ams_pkg::MODE_SAFE);
         done = 1'b1;
      end

      // Hold boot until the data is usable
      if (!done && w.st.mode == ams_pkg::MODE_BOOT) begin
         if (sensors_ready && attitude_ready && data_fresh) begin
            w = enter_mode(w, ams_pkg::MODE_SAFE);
         end else begin
            done = 1'b1;
         end
      end

      if (!done && tick.rate_mag > cfg.excessive_rate) begin
         w    = enter_mode(w, ams_pkg::MODE_SAFE);
         done = 1'b1;
      end

      if (!done) begin
         // Forced and requested transitions
         if (w.st.requested == ams_pkg::MODE_SAFE) begin
            w = enter_mode(w, ams_pkg::MODE_SAFE);
         end else if (tick.rate_mag > cfg.detumble_entry_rate) begin
            w = enter_mode(w, ams_pkg::MODE_DETUMBLE);
         end else if (w.st.mode != ams_pkg::MODE_DETUMBLE && w.st.requested != w.st.mode &&
                      allowed(w.st.requested, sensors_ready, attitude_ready,
                              sun_ok, nadir_ok, target_ok)) begin
            w = enter_mode(w, w.st.requested);
         end

         // Per-mode follow-up: recovery from safe, settling and slew completion
         case (w.st.mode)
            ams_pkg::MODE_SAFE: begin
               if (w.st.requested != ams_pkg::MODE_SAFE) begin
                  if (tick.rate_mag > cfg.detumble_entry_rate && sensors_ready) begin
                     w = enter_mode(w, ams_pkg::MODE_DETUMBLE);
                  end else if (allowed(w.st.requested, sensors_ready, attitude_ready,
                                       sun_ok, nadir_ok, target_ok)) begin
                     w = enter_mode(w, w.st.requested);
                  end
               end
            end
            ams_pkg::MODE_DETUMBLE: begin
               if (tick.rate_mag <= cfg.detumble_exit_rate) begin
                  w.st.stable = bump(w.st.stable);
                  if (w.st.stable >= cfg.detumble_settle_ticks) begin
                     w.st.requested = ams_pkg::MODE_SUN_ACQ;
                     if (attitude_ready && sun_ok) begin
                        w = enter_mode(w, ams_pkg::MODE_SUN_ACQ);
                     end
                  end
               end else begin
                  w.st.stable = '0;
               end
            end
            ams_pkg::MODE_SUN_ACQ: begin
               if (tick.pointing_error <= ams_pkg::SUN_SETTLED_ERROR &&
                   tick.rate_mag <= cfg.detumble_entry_rate) begin
                  w.st.stable = bump(w.st.stable);
                  if (w.st.stable >= cfg.sun_settle_ticks) begin
                     w.st.requested = ams_pkg::MODE_SUN_PT;
                     w = enter_mode(w, ams_pkg::MODE_SUN_PT);
                  end
               end else begin
                  w.st.stable = '0;
               end
            end
            ams_pkg::MODE_SLEW: begin
               if (tick.slew_done) begin
                  w.st.requested = ams_pkg::MODE_TARGET;
                  w = enter_mode(w, ams_pkg::MODE_TARGET);
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign nxt         = w.st;
   assign evt.entries = w.entries;
   assign evt.reject  = reject;

endmodule

// ===== rtl/attitude_mode_supervisor.sv =====
// Channel   | Direction | Handshake             | Payload
// ----------+-----------+-----------------------+------------------------------------
// req_      | in        | req_tvalid/req_tready | one supervisor tick (tdata, tuser)
// rsp_      | out       | rsp_tvalid/rsp_tready | mode and counters after the tick
// csr_      | in        | csr_valid/csr_ready   | register index and write data
//
// One tick per cycle sustained while rsp_tready stays high; a request is registered
// in the input register, then passes through the mode logic into the result register.
// The state update is a single pass through the mode rules.
// Reset clears the mode state, counters and configuration to their defaults.
// A stalled result holds the pipe; a new request is still taken while the
// input register can move forward. csr_ready is always high.

`include "attitude_mode_supervisor_assert.svh"

module attitude_mode_supervisor (
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   // [3:0] mode_request, [4] critical_fault, [7:5] sensor_flags,
   // [55:8] sensor_time, [103:56] attitude_time, [106:104] attitude_flags,
   // [122:107] confidence, [142:123] rate magnitude, [144:143] reference_flags,
   // [163:145] pointing_error, [164] slew settled, [167:165] zero
   input  logic [167:0] req_tdata,
   // [0] request_valid
   input  logic         req_tuser,

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [3:0] mode, [7:4] wanted_mode, [8] mode_changed, [24:9] stable_count,
   // [56:25] transition_count, [88:57] rejected_count, [95:89] zero
   output logic [95:0]  rsp_tdata,

   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);

   ams_pkg::cfg_type   cfg_ff, cfg_in;
   ams_pkg::tick_type  tick_ff, tick_in;
   logic               s1_valid_ff, s1_valid_in;
   ams_pkg::state_type state_ff, state_nxt;
   ams_pkg::event_type evt;
   logic [31:0]        transitions_ff, transitions_in;
   logic [31:0]        rejected_ff, rejected_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [95:0]        rsp_data_ff, rsp_data_in;
   logic               advance;
   logic               req_take;

   // Configuration writes
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            ams_pkg::CSR_DETUMBLE_ENTRY_RATE:   cfg_in.detumble_entry_rate   = csr_data[19:0];
            ams_pkg::CSR_DETUMBLE_EXIT_RATE:    cfg_in.detumble_exit_rate    = csr_data[19:0];
            ams_pkg::CSR_EXCESSIVE_RATE:        cfg_in.excessive_rate        = csr_data[19:0];
            ams_pkg::CSR_MIN_CONFIDENCE:        cfg_in.min_confidence        = csr_data[15:0];
            ams_pkg::CSR_DETUMBLE_SETTLE_TICKS: cfg_in.detumble_settle_ticks = csr_data[15:0];
            ams_pkg::CSR_SUN_SETTLE_TICKS:      cfg_in.sun_settle_ticks      = csr_data[15:0];
            ams_pkg::CSR_ESTIMATE_STALE_US:     cfg_in.estimate_stale_us     = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.detumble_entry_rate   <= 20'd1966;
         cfg_ff.detumble_exit_rate    <= 20'd524;
         cfg_ff.excessive_rate        <= 20'd49152;
         cfg_ff.min_confidence        <= 16'd11469;
         cfg_ff.detumble_settle_ticks <= 16'd20;
         cfg_ff.sun_settle_ticks      <= 16'd20;
         cfg_ff.estimate_stale_us     <= 32'd250000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Pipe control: the input register moves when the result register frees up
   assign advance     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || advance;
   assign req_take    = req_tvalid && req_tready;
   assign s1_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // Unpack the request
   always_comb begin
      tick_in.request_valid   = req_tuser;
      tick_in.mode_request    = req_tdata[3:0];
      tick_in.critical_fault  = req_tdata[4];
      tick_in.sensor_flags    = req_tdata[7:5];
      tick_in.sensor_time     = req_tdata[55:8];
      tick_in.attitude_time   = req_tdata[103:56];
      tick_in.attitude_flags  = req_tdata[106:104];
      tick_in.confidence      = req_tdata[122:107];
      tick_in.rate_mag        = req_tdata[142:123];
      tick_in.reference_flags = req_tdata[144:143];
      tick_in.pointing_error  = req_tdata[163:145];
      tick_in.slew_done       = req_tdata[164];
   end

   ams_step u_step (
      .cfg  (cfg_ff),
      .tick (tick_ff),
      .cur  (state_ff),
      .nxt  (state_nxt),
      .evt  (evt)
   );

   // Counters and result word
   assign transitions_in = transitions_ff + {30'd0, evt.entries};
   assign rejected_in    = rejected_ff + {31'd0, evt.reject};
   assign rsp_data_in    = {7'd0, rejected_in, transitions_in, state_nxt.stable,
                            (evt.entries != 2'd0), state_nxt.requested, state_nxt.mode};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         state_ff.mode      <= ams_pkg::MODE_BOOT;
         state_ff.requested <= ams_pkg::MODE_SUN_ACQ;
         state_ff.stable    <= '0;
         transitions_ff     <= '0;
         rejected_ff        <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff       <= state_nxt;
            transitions_ff <= transitions_in;
            rejected_ff    <= rejected_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         tick_ff <= tick_in;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks
   `AMS_ASSERT_NEXT(a_state_holds_idle, !advance, $stable(state_ff) && $stable(transitions_ff))
   `AMS_ASSERT_NEXT(a_no_entry, advance && (evt.entries == 2'd0), $stable(state_ff.mode))
   `AMS_ASSERT_NOW(a_requested_not_boot, 1'b1, state_ff.requested != ams_pkg::MODE_BOOT)
   `AMS_ASSERT_NOW(a_full_pipe_stalls, s1_valid_ff && rsp_valid_ff && !rsp_tready, !req_tready)

endmodule

// ===== sim/attitude_mode_supervisor_tb.sv =====
module attitude_mode_supervisor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASES       = 8;
   localparam int PHASE_TICKS  = 135;
   localparam int DRAIN_CYCLES = 6;

   // Index past the last register; writes to it must be dropped
   localparam logic [2:0] CSR_SPARE = 3'd7;

   localparam ams_pkg::cfg_type RESET_THRESHOLDS = ams_pkg::cfg_type'{
      20'd1966, 20'd524, 20'd49152, 16'd11469, 16'd20, 16'd20, 32'd250000};

   typedef enum int {THR_KEEP, THR_TYPICAL, THR_ZERO, THR_MAX, THR_RAW} thr_kind_type;

   // Mode and counters reported after one tick
   typedef struct packed {
      ams_pkg::mode_type mode;
      ams_pkg::mode_type wanted;
      logic              changed;
      logic [15:0]       stable;
      logic [31:0]       switches;
      logic [31:0]       rejects;
   } tick_status_type;

   // Values typed in by hand for a directed tick
   typedef struct packed {
      logic              on;
      ams_pkg::mode_type mode;
      ams_pkg::mode_type wanted;
      logic [31:0]       rejects;
   } mode_pin_type;

   typedef struct packed {
      ams_pkg::tick_type tick;
      mode_pin_type      pin;
   } script_row_type;

   localparam mode_pin_type NO_PIN = '0;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [167:0] req_tdata;
   logic         req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [95:0]  rsp_tdata;
   logic         csr_valid;
   logic         csr_ready;
   logic [2:0]   csr_index;
   logic [31:0]  csr_data;

   // Supervisor state as predicted
   ams_pkg::mode_type mode_now     = ams_pkg::MODE_BOOT;
   ams_pkg::mode_type wanted_now   = ams_pkg::MODE_SUN_ACQ;
   logic [15:0]       settle_now   = '0;
   logic [31:0]       switches_now = '0;
   logic [31:0]       rejects_now  = '0;
   int                entries_this_tick;
   ams_pkg::cfg_type  thresholds   = RESET_THRESHOLDS;

   tick_status_type status_due[$];
   script_row_type  script[$];
   int              idle_odds     = 4;
   int              errors        = 0;
   int              ticks_sent    = 0;
   int              statuses_seen = 0;
   logic [8:0]      modes_seen    = '0;

   attitude_mode_supervisor u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("attitude_mode_supervisor_tb: FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic bit sensors_good(ams_pkg::tick_type t);
      return t.sensor_time != '0 && t.sensor_flags[1:0] == 2'b11;
   endfunction

   function automatic bit estimate_good(ams_pkg::tick_type t);
      return t.attitude_flags[0] && t.attitude_time != '0 &&
             t.confidence >= thresholds.min_confidence && t.attitude_flags[1];
   endfunction

   function automatic bit may_enter(ams_pkg::mode_type m, ams_pkg::tick_type t);
      case (m)
         ams_pkg::MODE_SAFE:
            return 1'b1;
         ams_pkg::MODE_DETUMBLE:
            return sensors_good(t);
         ams_pkg::MODE_SUN_ACQ, ams_pkg::MODE_SUN_PT:
            return estimate_good(t) && t.sensor_flags[2] && t.reference_flags[0];
         ams_pkg::MODE_EARTH:
            return estimate_good(t) && t.reference_flags[1];
         ams_pkg::MODE_SLEW, ams_pkg::MODE_TARGET, ams_pkg::MODE_SCIENCE:
            return estimate_good(t) && t.attitude_flags[2];
         default:
            return 1'b0;
      endcase
   endfunction

   function automatic void switch_mode(ams_pkg::mode_type m);
      if (mode_now != m) begin
         mode_now     = m;
         settle_now   = '0;
         switches_now = switches_now + 32'd1;
         entries_this_tick++;
      end
   endfunction

   function automatic void count_settle();
      if (settle_now != ams_pkg::STABLE_MAX) begin
         settle_now = settle_now + 16'd1;
      end
   endfunction

   function automatic void apply_rules(ams_pkg::tick_type t);
      logic [ams_pkg::TIME_BITS-1:0] age;
      age = t.sensor_time - t.attitude_time;
      if (t.critical_fault) begin
         switch_mode(ams_pkg::MODE_SAFE);
         return;
      end
      // Leave boot only on ready sensors and a fresh estimate
      if (mode_now == ams_pkg::MODE_BOOT) begin
         if (sensors_good(t) && estimate_good(t) && t.attitude_time <= t.sensor_time &&
             age <= ams_pkg::TIME_BITS'(thresholds.estimate_stale_us)) begin
            switch_mode(ams_pkg::MODE_SAFE);
         end else begin
            return;
         end
      end
      if (t.rate_mag > thresholds.excessive_rate) begin
         switch_mode(ams_pkg::MODE_SAFE);
         return;
      end
      if (wanted_now == ams_pkg::MODE_SAFE) begin
         switch_mode(ams_pkg::MODE_SAFE);
      end else if (t.rate_mag > thresholds.detumble_entry_rate) begin
         switch_mode(ams_pkg::MODE_DETUMBLE);
      end else if (mode_now != ams_pkg::MODE_DETUMBLE && wanted_now != mode_now &&
                   may_enter(wanted_now, t)) begin
         switch_mode(wanted_now);
      end
      // Per-mode follow-up: recovery from safe, settle counters, slew completion
      case (mode_now)
         ams_pkg::MODE_SAFE: begin
            if (wanted_now != ams_pkg::MODE_SAFE) begin
               if (t.rate_mag > thresholds.detumble_entry_rate && sensors_good(t)) begin
                  switch_mode(ams_pkg::MODE_DETUMBLE);
               end else if (may_enter(wanted_now, t)) begin
                  switch_mode(wanted_now);
               end
            end
         end
         ams_pkg::MODE_DETUMBLE: begin
            if (t.rate_mag <= thresholds.detumble_exit_rate) begin
               count_settle();
               if (settle_now >= thresholds.detumble_settle_ticks) begin
                  wanted_now = ams_pkg::MODE_SUN_ACQ;
                  if (may_enter(ams_pkg::MODE_SUN_ACQ, t)) begin
                     switch_mode(ams_pkg::MODE_SUN_ACQ);
                  end
               end
            end else begin
               settle_now = '0;
            end
         end
         ams_pkg::MODE_SUN_ACQ: begin
            if (t.pointing_error <= ams_pkg::SUN_SETTLED_ERROR &&
                t.rate_mag <= thresholds.detumble_entry_rate) begin
               count_settle();
               if (settle_now >= thresholds.sun_settle_ticks) begin
                  wanted_now = ams_pkg::MODE_SUN_PT;
                  switch_mode(ams_pkg::MODE_SUN_PT);
               end
            end else begin
               settle_now = '0;
            end
         end
         ams_pkg::MODE_SLEW: begin
            if (t.slew_done) begin
               wanted_now = ams_pkg::MODE_TARGET;
               switch_mode(ams_pkg::MODE_TARGET);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic tick_status_type step_supervisor(ams_pkg::tick_type t);
      tick_status_type s;
      entries_this_tick = 0;
      // Apply the request before the mode rules run
      if (t.request_valid) begin
         if (t.mode_request >= ams_pkg::MODE_SAFE && t.mode_request <= ams_pkg::MODE_SCIENCE) begin
            wanted_now = ams_pkg::mode_type'(t.mode_request);
         end else begin
            rejects_now = rejects_now + 32'd1;
         end
      end
      apply_rules(t);
      s.mode     = mode_now;
      s.wanted   = wanted_now;
      s.changed  = (entries_this_tick != 0);
      s.stable   = settle_now;
      s.switches = switches_now;
      s.rejects  = rejects_now;
      return s;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic mode_pin_type pin_of(ams_pkg::mode_type m, ams_pkg::mode_type w,
                                           int unsigned rej);
      mode_pin_type p;
      p.on      = 1'b1;
      p.mode    = m;
      p.wanted  = w;
      p.rejects = rej;
      return p;
   endfunction

   function automatic ams_pkg::tick_type make_tick();
      ams_pkg::tick_type             t;
      logic [191:0]                  noise;
      logic [ams_pkg::TIME_BITS-1:0] now;
      int                            sel;
      int                            r;
      // Some ticks are pure noise over every field
      if ($urandom_range(0, 9) == 0) begin
         noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         t = noise[$bits(ams_pkg::tick_type)-1:0];
         return t;
      end
      t.request_valid = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         t.mode_request = ams_pkg::MODE_BOOT;
      end else if (sel == 1) begin
         t.mode_request = 4'($urandom_range(9, 15));
      end else begin
         t.mode_request = 4'($urandom_range(ams_pkg::MODE_SAFE, ams_pkg::MODE_SCIENCE));
      end
      t.critical_fault = ($urandom_range(0, 29) == 0);
      t.sensor_flags   = ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'b111;
      now = {16'($urandom), 32'($urandom)};
      sel = $urandom_range(0, 31);
      if (sel == 0) begin
         now = '0;
      end else if (sel == 1) begin
         now = '1;
      end
      t.sensor_time = now;
      sel = $urandom_range(0, 15);
      if (sel == 0) begin
         t.attitude_time = '0;
      end else if (sel == 1) begin
         t.attitude_time = {16'($urandom), 32'($urandom)};
      end else begin
         t.attitude_time = now - ams_pkg::TIME_BITS'($urandom_range(0, 300000));
      end
      t.attitude_flags = ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'b111;
      t.confidence = ($urandom_range(0, 7) == 0) ? 16'($urandom) :
                     16'($urandom_range(thresholds.min_confidence, 32768));
      // Rates cluster around the thresholds in force
      sel = $urandom_range(0, 15);
      if (sel < 7) begin
         r = $urandom_range(0, thresholds.detumble_exit_rate);
      end else if (sel < 10) begin
         r = thresholds.detumble_exit_rate + $urandom_range(0, 4) - 2;
      end else if (sel < 12) begin
         r = thresholds.detumble_entry_rate + $urandom_range(0, 4) - 2;
      end else if (sel < 14) begin
         r = thresholds.excessive_rate + $urandom_range(0, 4) - 2;
      end else if (sel == 14) begin
         r = 20'hFFFFF;
      end else begin
         r = $urandom_range(0, 20'hFFFFF);
      end
      if (r < 0) r = 0;
      if (r > 20'hFFFFF) r = 20'hFFFFF;
      t.rate_mag        = 20'(r);
      t.reference_flags = ($urandom_range(0, 7) == 0) ? 2'($urandom) : 2'b11;
      sel = $urandom_range(0, 7);
      if (sel < 5) begin
         t.pointing_error = 19'($urandom_range(0, ams_pkg::SUN_SETTLED_ERROR));
      end else if (sel < 7) begin
         t.pointing_error = 19'(ams_pkg::SUN_SETTLED_ERROR + $urandom_range(0, 2) - 1);
      end else begin
         t.pointing_error = 19'($urandom);
      end
      t.slew_done = ($urandom_range(0, 2) == 0);
      return t;
   endfunction

   // Offer one tick; predict its status once the request is taken
   task automatic push_tick(input ams_pkg::tick_type t, input mode_pin_type pin);
      tick_status_type due;
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= t.request_valid;
      req_tdata  <= {3'b000, t.slew_done, t.pointing_error, t.reference_flags,
                     t.rate_mag, t.confidence, t.attitude_flags, t.attitude_time,
                     t.sensor_time, t.sensor_flags, t.critical_fault, t.mode_request};
      do @(posedge clock); while (!req_tready);
      due = step_supervisor(t);
      if (pin.on) begin
         due.mode    = pin.mode;
         due.wanted  = pin.wanted;
         due.rejects = pin.rejects;
      end
      status_due.push_back(due);
      ticks_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         ams_pkg::CSR_DETUMBLE_ENTRY_RATE:   thresholds.detumble_entry_rate   = value[19:0];
         ams_pkg::CSR_DETUMBLE_EXIT_RATE:    thresholds.detumble_exit_rate    = value[19:0];
         ams_pkg::CSR_EXCESSIVE_RATE:        thresholds.excessive_rate        = value[19:0];
         ams_pkg::CSR_MIN_CONFIDENCE:        thresholds.min_confidence        = value[15:0];
         ams_pkg::CSR_DETUMBLE_SETTLE_TICKS: thresholds.detumble_settle_ticks = value[15:0];
         ams_pkg::CSR_SUN_SETTLE_TICKS:      thresholds.sun_settle_ticks      = value[15:0];
         ams_pkg::CSR_ESTIMATE_STALE_US:     thresholds.estimate_stale_us     = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_thresholds(input thr_kind_type kind);
      logic [31:0] v [7];
      int          entry;
      case (kind)
         THR_KEEP: return;
         THR_ZERO: foreach (v[i]) v[i] = '0;
         THR_MAX:  foreach (v[i]) v[i] = '1;
         THR_RAW:  foreach (v[i]) v[i] = $urandom;
         default: begin
            entry = $urandom_range(300, 6000);
            v[ams_pkg::CSR_DETUMBLE_ENTRY_RATE]   = entry;
            v[ams_pkg::CSR_DETUMBLE_EXIT_RATE]    = $urandom_range(0, entry);
            v[ams_pkg::CSR_EXCESSIVE_RATE]        = $urandom_range(entry, 70000);
            v[ams_pkg::CSR_MIN_CONFIDENCE]        = $urandom_range(0, 32768);
            v[ams_pkg::CSR_DETUMBLE_SETTLE_TICKS] = $urandom_range(1, 4);
            v[ams_pkg::CSR_SUN_SETTLE_TICKS]      = $urandom_range(1, 4);
            v[ams_pkg::CSR_ESTIMATE_STALE_US]     = $urandom_range(1, 400000);
         end
      endcase
      foreach (v[i]) write_reg(3'(i), v[i]);
      write_reg(CSR_SPARE, $urandom);
      csr_valid <= 1'b0;
   endtask

   // Drop valid and wait until every status is back
   task automatic drain_ticks();
      req_tvalid <= 1'b0;
      while (status_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // ---------------------------------------------------------------- checking

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   // Randomly stall the status side
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(negedge clock);
         if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Compare each delivered status with the oldest prediction
   always @(posedge clock) begin
      tick_status_type got;
      tick_status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.mode     = ams_pkg::mode_type'(rsp_tdata[3:0]);
         got.wanted   = ams_pkg::mode_type'(rsp_tdata[7:4]);
         got.changed  = rsp_tdata[8];
         got.stable   = rsp_tdata[24:9];
         got.switches = rsp_tdata[56:25];
         got.rejects  = rsp_tdata[88:57];
         statuses_seen++;
         if (got.mode <= ams_pkg::MODE_SCIENCE) modes_seen[got.mode] = 1'b1;
         if (status_due.size() == 0) begin
            $error("status delivered with no request outstanding");
            errors++;
         end else begin
            want = status_due.pop_front();
            check_field("mode", 32'(want.mode), 32'(got.mode));
            check_field("wanted_mode", 32'(want.wanted), 32'(got.wanted));
            check_field("mode_changed", 32'(want.changed), 32'(got.changed));
            check_field("stable_count", 32'(want.stable), 32'(got.stable));
            check_field("transition_count", want.switches, got.switches);
            check_field("rejected_count", want.rejects, got.rejects);
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      ams_pkg::tick_type base;
      ams_pkg::tick_type row;
      thr_kind_type      plan [PHASES];

      plan = '{THR_KEEP, THR_TYPICAL, THR_ZERO, THR_TYPICAL, THR_MAX, THR_RAW,
               THR_TYPICAL, THR_TYPICAL};

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= ams_pkg::CSR_DETUMBLE_ENTRY_RATE;
      csr_data   <= '0;

      // Healthy snapshot: every sensor and reference good, estimate 1 ms old
      base                 = '0;
      base.sensor_flags    = 3'b111;
      base.sensor_time     = 48'd1_000_000;
      base.attitude_time   = 48'd999_000;
      base.attitude_flags  = 3'b111;
      base.confidence      = 16'd32768;
      base.reference_flags = 2'b11;

      // Boot holds while anything is missing; bad requests are counted
      row = '0;
      script.push_back(script_row_type'{row,
         pin_of(ams_pkg::MODE_BOOT, ams_pkg::MODE_SUN_ACQ, 0)});
      row.request_valid = 1'b1;
      row.mode_request  = ams_pkg::MODE_BOOT;
      script.push_back(script_row_type'{row,
         pin_of(ams_pkg::MODE_BOOT, ams_pkg::MODE_SUN_ACQ, 1)});
      row.mode_request  = 4'd15;
      script.push_back(script_row_type'{row,
         pin_of(ams_pkg::MODE_BOOT, ams_pkg::MODE_SUN_ACQ, 2)});
      row = base;
      row.attitude_time = 48'd1_000_001;
      script.push_back(script_row_type'{row,
         pin_of(ams_pkg::MODE_BOOT, ams_pkg::MODE_SUN_ACQ, 2)});
      row.attitude_time = 48'd749_999;
      script.push_back(script_row_type'{row,
         pin_of(ams_pkg::MODE_BOOT, ams_pkg::MODE_SUN_ACQ, 2)});
      row = base;
      row.confidence = 16'd11468;
      script.push_back(script_row_type'{row,
         pin_of(ams_pkg::MODE_BOOT, ams_pkg::MODE_SUN_ACQ, 2)});
      row = base;
      row.sensor_flags = 3'b110;
      script.push_back(script_row_type'{row,
         pin_of(ams_pkg::MODE_BOOT, ams_pkg::MODE_SUN_ACQ, 2)});
      row = base;
      row.attitude_time = '0;
      script.push_back(script_row_type'{row,
         pin_of(ams_pkg::MODE_BOOT, ams_pkg::MODE_SUN_ACQ, 2)});
      row = base;
      row.sensor_time = '0;
      script.push_back(script_row_type'{row,
         pin_of(ams_pkg::MODE_BOOT, ams_pkg::MODE_SUN_ACQ, 2)});
      row = base;
      row.attitude_flags = 3'b101;
      script.push_back(script_row_type'{row,
         pin_of(ams_pkg::MODE_BOOT, ams_pkg::MODE_SUN_ACQ, 2)});

      // Estimate exactly at the age limit, confidence exactly at the floor
      row = base;
      row.attitude_time = 48'd750_000;
      row.confidence    = 16'd11469;
      script.push_back(script_row_type'{row, NO_PIN});

      // Walk the modes by request
      row = base;
      row.request_valid = 1'b1;
      row.mode_request  = ams_pkg::MODE_SAFE;
      script.push_back(script_row_type'{row,
         pin_of(ams_pkg::MODE_SAFE, ams_pkg::MODE_SAFE, 2)});
      row.mode_request  = ams_pkg::MODE_DETUMBLE;
      script.push_back(script_row_type'{row, NO_PIN});
      row = base;
      row.rate_mag = 20'hFFFFF;
      script.push_back(script_row_type'{row,
         pin_of(ams_pkg::MODE_SAFE, ams_pkg::MODE_DETUMBLE, 2)});
      row = base;
      row.critical_fault = 1'b1;
      row.request_valid  = 1'b1;
      row.mode_request   = 4'd12;
      script.push_back(script_row_type'{row,
         pin_of(ams_pkg::MODE_SAFE, ams_pkg::MODE_DETUMBLE, 3)});
      row = base;
      row.request_valid = 1'b1;
      row.mode_request  = ams_pkg::MODE_EARTH;
      script.push_back(script_row_type'{row, NO_PIN});
      row.mode_request  = ams_pkg::MODE_SLEW;
      script.push_back(script_row_type'{row, NO_PIN});
      row = base;
      row.slew_done = 1'b1;
      script.push_back(script_row_type'{row, NO_PIN});
      row = base;
      row.request_valid = 1'b1;
      row.mode_request  = ams_pkg::MODE_SCIENCE;
      script.push_back(script_row_type'{row, NO_PIN});
      row.mode_request  = ams_pkg::MODE_SUN_PT;
      script.push_back(script_row_type'{row, NO_PIN});

      // Sun acquisition settle test around the pointing threshold
      row.mode_request   = ams_pkg::MODE_SUN_ACQ;
      row.pointing_error = 19'h7FFFF;
      script.push_back(script_row_type'{row, NO_PIN});
      row = base;
      row.pointing_error = ams_pkg::SUN_SETTLED_ERROR;
      script.push_back(script_row_type'{row, NO_PIN});
      row.pointing_error = ams_pkg::SUN_SETTLED_ERROR + 19'd1;
      script.push_back(script_row_type'{row, NO_PIN});
      row = base;
      row.rate_mag = RESET_THRESHOLDS.detumble_entry_rate + 20'd1;
      script.push_back(script_row_type'{row, NO_PIN});

      // Time and confidence fields at their tops
      row = base;
      row.sensor_time   = '1;
      row.attitude_time = '1;
      row.confidence    = 16'hFFFF;
      script.push_back(script_row_type'{row, NO_PIN});

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (script[i]) push_tick(script[i].tick, script[i].pin);

      // Random phases, each under its own thresholds; the last runs without idling
      for (int p = 0; p < PHASES; p++) begin
         drain_ticks();
         if (p == PHASES - 1) begin
            idle_odds = 0;
         end else begin
            idle_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 8);
         end
         set_thresholds(plan[p]);
         repeat (PHASE_TICKS) push_tick(make_tick(), NO_PIN);
      end
      drain_ticks();

      $display("summary: %0d ticks, %0d statuses, %0d mode changes, %0d rejected requests",
               ticks_sent, statuses_seen, switches_now, rejects_now);
      $display("summary: %0d threshold phases, modes reached (bit per mode) %b",
               PHASES, modes_seen);
      if (errors == 0) begin
         $display("attitude_mode_supervisor_tb: PASS");
      end else begin
         $display("attitude_mode_supervisor_tb: FAIL");
      end
      $finish;
   end

endmodule
